### design/yuv_frame_to_rgb_macros.svh
// ----------------------------------------------------------------------------
// yuv_frame_to_rgb assertion macros
// shared property shorthands for the checker of the yuv to rgb frame store
// ----------------------------------------------------------------------------
`ifndef YUV_FRAME_TO_RGB_MACROS_SVH
`define YUV_FRAME_TO_RGB_MACROS_SVH

// antecedent implies consequent in the same cycle
`define YFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("yuv_frame_to_rgb check failed");

// antecedent implies consequent in the next cycle
`define YFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("yuv_frame_to_rgb check failed");

`endif

### design/yuvrgb_pkg.sv
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// types, codes and conversion tables of the yuv to rgb frame store
// ----------------------------------------------------------------------------
`default_nettype none

package yuvrgb_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORMAT = 2'd2;

  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 10;

  // transaction codes
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_CONVERT = 1'b1;
  localparam logic FMT_YV12     = 1'b0;
  localparam logic FMT_YUY2     = 1'b1;

  // widest store address that a request can form before wrapping
  localparam int ADDR_REACH_W = 22;
  // multiplier operand widths: geometry times row or height
  localparam int MUL_A_W = 11;
  localparam int MUL_B_W = 10;

  // channel clamp limit, 255 << 8
  localparam int CHAN_MAX = 255 << 8;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_MUL,
    ALU_MOD
  } yuvrgb_alu_op_e;

  typedef struct packed {
    logic        mode;
    logic [19:0] byte_address;
    logic [7:0]  byte_value;
    logic [9:0]  column;
    logic [8:0]  row;
  } yuvrgb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       outside_frame;
  } yuvrgb_out_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] cr;
    logic [7:0] cb;
  } yuvrgb_bytes_t;

  // conversion tables
  localparam int ROM_W     = 18;
  localparam int ROM_DEPTH = 256;
  typedef logic signed [ROM_W-1:0] yuvrgb_rom_t [ROM_DEPTH];

  localparam int ROM_SEL_Y   = 0;
  localparam int ROM_SEL_RCR = 1;
  localparam int ROM_SEL_GCR = 2;
  localparam int ROM_SEL_GCB = 3;
  localparam int ROM_SEL_BCB = 4;

  // integer quotients truncate toward zero
  function automatic yuvrgb_rom_t build_rom(int sel);
    yuvrgb_rom_t rom;
    int          v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      case (sel)
        ROM_SEL_Y:   v = (i - 16) * 65280 / 219;
        ROM_SEL_RCR: v = (i - 128) * 356108 / 875;
        ROM_SEL_GCR: v = (i - 128) * (-25908) / 125;
        ROM_SEL_GCB: v = (i - 128) * (-87376) / 875;
        ROM_SEL_BCB: v = (i - 128) * 450088 / 875;
        default:     v = 0;
      endcase
      rom[i] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam yuvrgb_rom_t ROM_Y   = build_rom(ROM_SEL_Y);
  localparam yuvrgb_rom_t ROM_RCR = build_rom(ROM_SEL_RCR);
  localparam yuvrgb_rom_t ROM_GCR = build_rom(ROM_SEL_GCR);
  localparam yuvrgb_rom_t ROM_GCB = build_rom(ROM_SEL_GCB);
  localparam yuvrgb_rom_t ROM_BCB = build_rom(ROM_SEL_BCB);

endpackage

`default_nettype wire

### design/yuvrgb_ram.sv
// ----------------------------------------------------------------------------
// yuvrgb_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module yuvrgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

### design/yuvrgb_alu.sv
// ----------------------------------------------------------------------------
// yuvrgb_alu
// shared multiply, add and modulo-step unit for address generation
// ----------------------------------------------------------------------------
`default_nettype none

module yuvrgb_alu #(
  parameter int DW          = 22,
  parameter int STORE_BYTES = 1048576
) (
  input  wire yuvrgb_pkg::yuvrgb_alu_op_e op_i,
  input  wire logic [DW-1:0]              a_i,
  input  wire logic [DW-1:0]              b_i,
  output logic      [DW-1:0]              res_o
);

  localparam bit POW2 = (STORE_BYTES & (STORE_BYTES - 1)) == 0;

  logic [yuvrgb_pkg::MUL_A_W+yuvrgb_pkg::MUL_B_W-1:0] prod;

  assign prod = a_i[yuvrgb_pkg::MUL_A_W-1:0] * b_i[yuvrgb_pkg::MUL_B_W-1:0];

  always_comb begin
    case (op_i)
      yuvrgb_pkg::ALU_ADD: res_o = a_i + b_i;
      yuvrgb_pkg::ALU_MUL: res_o = DW'(prod);
      yuvrgb_pkg::ALU_MOD: begin
        // power-of-two store wraps by mask, else one restoring step
        if (POW2) begin
          res_o = a_i & DW'(STORE_BYTES - 1);
        end else begin
          res_o = (a_i >= b_i) ? (a_i - b_i) : a_i;
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/yuvrgb_conv.sv
// ----------------------------------------------------------------------------
// yuvrgb_conv
// table lookup and clamp from one luma and two chroma bytes to rgb
// ----------------------------------------------------------------------------
`default_nettype none

module yuvrgb_conv (
  input  wire logic                      clk_i,
  input  wire logic                      load_i,
  input  wire yuvrgb_pkg::yuvrgb_bytes_t bytes_i,
  output logic [7:0]                     red_o,
  output logic [7:0]                     green_o,
  output logic [7:0]                     blue_o
);

  localparam int SUM_W = 20;
  localparam logic signed [SUM_W-1:0] LIMIT = SUM_W'(yuvrgb_pkg::CHAN_MAX);

  logic signed [yuvrgb_pkg::ROM_W-1:0] y_q, rcr_q, gcr_q, gcb_q, bcb_q;
  logic signed [SUM_W-1:0]             r_sum, g_sum, b_sum;

  function automatic logic [7:0] clamp_chan(logic signed [SUM_W-1:0] s);
    logic [16:0] v;
    if (s[SUM_W-1]) begin
      v = '0;
    end else if (s > LIMIT) begin
      v = 17'(yuvrgb_pkg::CHAN_MAX);
    end else begin
      v = s[16:0];
    end
    v = v + 17'd127;
    return v[15:8];
  endfunction

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      y_q   <= yuvrgb_pkg::ROM_Y[bytes_i.y];
      rcr_q <= yuvrgb_pkg::ROM_RCR[bytes_i.cr];
      gcr_q <= yuvrgb_pkg::ROM_GCR[bytes_i.cr];
      gcb_q <= yuvrgb_pkg::ROM_GCB[bytes_i.cb];
      bcb_q <= yuvrgb_pkg::ROM_BCB[bytes_i.cb];
    end
  end

  assign r_sum = SUM_W'(y_q) + SUM_W'(rcr_q);
  assign g_sum = SUM_W'(y_q) + SUM_W'(gcr_q) + SUM_W'(gcb_q);
  assign b_sum = SUM_W'(y_q) + SUM_W'(bcb_q);

  assign red_o   = clamp_chan(r_sum);
  assign green_o = clamp_chan(g_sum);
  assign blue_o  = clamp_chan(b_sum);

endmodule

`default_nettype wire

### design/yuv_frame_to_rgb.sv
// ----------------------------------------------------------------------------
// yuv_frame_to_rgb
// byte-addressed frame store with a bt.601 yuv to rgb pixel converter
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o / in_data_i): a transaction either
//   writes one frame byte (mode 0) or asks for the rgb of one pixel (mode 1).
//   output channel (out_valid_o / out_stall_i / out_data_o): one transaction
//   per pixel request, none per byte write. cfg_ready_o is always high.
//   config channel (cfg_valid_i / cfg_ready_o): the user writes width, height
//   and format only while the block is idle; the block does not enforce it.
// sequence, with an address wrap of one mask step for a power-of-two store,
// otherwise 23 - clog2(STORE_BYTES) restoring steps (at least one):
//   a yv12 request forms its pixel index and chroma addresses in the alu, a
//   yuy2 request derives them from its pixel index; each byte is then wrapped,
//   read and captured, and the tables feed the output register; an outside
//   request goes straight there. a byte write wraps its address and writes.
//   the next transaction can be taken in the cycle the result appears.
//   one shared alu forms all addresses and the single-port store gives one
//   byte per read, so the three byte fetches of a pixel run one after another.
//   in_stall_o is high while a transaction is in work.
// reset clears the sequencer, the output valid and the configuration to
// 16 x 16 yv12; the store content is undefined until written. a stalled
// result sits in the output register while the next write proceeds; a new
// pixel result waits in its final step until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_frame_to_rgb #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 512,
  parameter int STORE_BYTES = 1048576
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // input transactions
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire yuvrgb_pkg::yuvrgb_in_t                in_data_i,
  // result transactions
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output yuvrgb_pkg::yuvrgb_out_t                    out_data_o,
  // configuration writes
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [yuvrgb_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire logic [yuvrgb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // store address width and the working width of the address path
  localparam int AW    = $clog2(STORE_BYTES);
  localparam int DW    = (AW > yuvrgb_pkg::ADDR_REACH_W) ? AW : yuvrgb_pkg::ADDR_REACH_W;
  localparam bit POW2  = (STORE_BYTES & (STORE_BYTES - 1)) == 0;
  // reduction starts at the largest shifted modulus below 2**DW
  localparam int MOD_K = (AW < yuvrgb_pkg::ADDR_REACH_W) ? (yuvrgb_pkg::ADDR_REACH_W - AW) : 0;
  localparam logic [DW-1:0] MOD_INIT = DW'(longint'(STORE_BYTES) << MOD_K);
  localparam logic [DW-1:0] MOD_LAST = DW'(STORE_BYTES);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_P_MUL   = 4'd1;
  localparam logic [3:0] S_P_ADD   = 4'd2;
  localparam logic [3:0] S_CR_MUL  = 4'd3;
  localparam logic [3:0] S_S_MUL   = 4'd4;
  localparam logic [3:0] S_S_ADD   = 4'd5;
  localparam logic [3:0] S_CB_MUL  = 4'd6;
  localparam logic [3:0] S_CR_ADD  = 4'd7;
  localparam logic [3:0] S_CB_ADD1 = 4'd8;
  localparam logic [3:0] S_CB_ADD2 = 4'd9;
  localparam logic [3:0] S_RED     = 4'd10;
  localparam logic [3:0] S_RD      = 4'd11;
  localparam logic [3:0] S_CAP     = 4'd12;
  localparam logic [3:0] S_WR      = 4'd13;
  localparam logic [3:0] S_ROM     = 4'd14;
  localparam logic [3:0] S_OUT     = 4'd15;

  // which of the three pixel bytes is being fetched
  localparam logic [1:0] SEL_Y  = 2'd0;
  localparam logic [1:0] SEL_CR = 2'd1;
  localparam logic [1:0] SEL_CB = 2'd2;

  // control state
  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic [yuvrgb_pkg::WIDTH_W-1:0]  width_q;
  logic [yuvrgb_pkg::HEIGHT_W-1:0] height_q;
  logic                            format_q;

  // payload state
  logic [1:0]                sel_q, sel_d;
  logic                      wr_q, wr_d;
  logic                      outside_q, outside_d;
  logic [8:0]                row_q, row_d;
  logic [9:0]                col_q, col_d;
  logic [7:0]                value_q, value_d;
  logic [DW-1:0]             cur_q, cur_d;
  logic [DW-1:0]             mod_q, mod_d;
  logic [DW-1:0]             tmp0_q, tmp0_d;
  logic [DW-1:0]             tmp1_q, tmp1_d;
  logic [DW-1:0]             tmp2_q, tmp2_d;
  logic [DW-1:0]             addr_q [3];
  logic [DW-1:0]             addr_d [3];
  yuvrgb_pkg::yuvrgb_bytes_t bytes_q, bytes_d;
  yuvrgb_pkg::yuvrgb_out_t   out_data_q, out_data_d;

  // effective geometry, oversize values act as the maximum
  logic [yuvrgb_pkg::WIDTH_W-1:0]  w_eff;
  logic [yuvrgb_pkg::HEIGHT_W-1:0] h_eff;

  logic                        in_accept;
  logic                        outside;
  yuvrgb_pkg::yuvrgb_alu_op_e  alu_op;
  logic [DW-1:0]               alu_a, alu_b, alu_res;
  logic [7:0]                  ram_rdata;
  logic                        conv_load;
  logic [7:0]                  conv_red, conv_green, conv_blue;

  assign w_eff = (32'(width_q) > 32'(MAX_WIDTH)) ? yuvrgb_pkg::WIDTH_W'(MAX_WIDTH) : width_q;
  assign h_eff = (32'(height_q) > 32'(MAX_HEIGHT)) ? yuvrgb_pkg::HEIGHT_W'(MAX_HEIGHT)
                                                   : height_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // a zero width or height leaves no column or row inside
  assign outside = ({1'b0, in_data_i.column} >= w_eff) || ({1'b0, in_data_i.row} >= h_eff);

  yuvrgb_alu #(
    .DW          (DW),
    .STORE_BYTES (STORE_BYTES)
  ) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  yuvrgb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WR),
    .re_i    (state_q == S_RD),
    .addr_i  (cur_q[AW-1:0]),
    .wdata_i (value_q),
    .rdata_o (ram_rdata)
  );

  yuvrgb_conv u_conv (
    .clk_i   (clk_i),
    .load_i  (conv_load),
    .bytes_i (bytes_q),
    .red_o   (conv_red),
    .green_o (conv_green),
    .blue_o  (conv_blue)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    sel_d       = sel_q;
    wr_d        = wr_q;
    outside_d   = outside_q;
    row_d       = row_q;
    col_d       = col_q;
    value_d     = value_q;
    cur_d       = cur_q;
    mod_d       = mod_q;
    tmp0_d      = tmp0_q;
    tmp1_d      = tmp1_q;
    tmp2_d      = tmp2_q;
    addr_d      = addr_q;
    bytes_d     = bytes_q;
    out_data_d  = out_data_q;
    alu_op      = yuvrgb_pkg::ALU_ADD;
    alu_a       = '0;
    alu_b       = '0;
    conv_load   = 1'b0;

    // a taken result frees the output register
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          row_d   = in_data_i.row;
          col_d   = in_data_i.column;
          value_d = in_data_i.byte_value;
          if (in_data_i.mode == yuvrgb_pkg::MODE_WRITE) begin
            wr_d    = 1'b1;
            cur_d   = DW'(in_data_i.byte_address);
            mod_d   = MOD_INIT;
            state_d = S_RED;
          end else begin
            wr_d      = 1'b0;
            outside_d = outside;
            state_d   = outside ? S_OUT : S_P_MUL;
          end
        end
      end
      // pixel index row * w + col
      S_P_MUL: begin
        alu_op  = yuvrgb_pkg::ALU_MUL;
        alu_a   = DW'(w_eff);
        alu_b   = DW'(row_q);
        tmp0_d  = alu_res;
        state_d = S_P_ADD;
      end
      S_P_ADD: begin
        alu_op = yuvrgb_pkg::ALU_ADD;
        alu_a  = tmp0_q;
        alu_b  = DW'(col_q);
        if (format_q == yuvrgb_pkg::FMT_YV12) begin
          addr_d[SEL_Y] = alu_res;
          state_d       = S_CR_MUL;
        end else begin
          // packed groups: luma at 2p, cb and cr at the group base + 1 and + 3
          addr_d[SEL_Y]  = {alu_res[DW-2:0], 1'b0};
          addr_d[SEL_CR] = {alu_res[DW-2:1], 2'b11};
          addr_d[SEL_CB] = {alu_res[DW-2:1], 2'b01};
          sel_d          = SEL_Y;
          cur_d          = {alu_res[DW-2:0], 1'b0};
          mod_d          = MOD_INIT;
          state_d        = S_RED;
        end
      end
      // planar: cr base w * h
      S_CR_MUL: begin
        alu_op  = yuvrgb_pkg::ALU_MUL;
        alu_a   = DW'(w_eff);
        alu_b   = DW'(h_eff);
        tmp0_d  = alu_res;
        state_d = S_S_MUL;
      end
      // chroma offset (row/2) * (w/2) + col/2
      S_S_MUL: begin
        alu_op  = yuvrgb_pkg::ALU_MUL;
        alu_a   = DW'(w_eff >> 1);
        alu_b   = DW'(row_q >> 1);
        tmp1_d  = alu_res;
        state_d = S_S_ADD;
      end
      S_S_ADD: begin
        alu_op  = yuvrgb_pkg::ALU_ADD;
        alu_a   = tmp1_q;
        alu_b   = DW'(col_q >> 1);
        tmp1_d  = alu_res;
        state_d = S_CB_MUL;
      end
      // quarter plane size (w/2) * (h/2)
      S_CB_MUL: begin
        alu_op  = yuvrgb_pkg::ALU_MUL;
        alu_a   = DW'(w_eff >> 1);
        alu_b   = DW'(h_eff >> 1);
        tmp2_d  = alu_res;
        state_d = S_CR_ADD;
      end
      S_CR_ADD: begin
        alu_op         = yuvrgb_pkg::ALU_ADD;
        alu_a          = tmp0_q;
        alu_b          = tmp1_q;
        addr_d[SEL_CR] = alu_res;
        state_d        = S_CB_ADD1;
      end
      S_CB_ADD1: begin
        alu_op  = yuvrgb_pkg::ALU_ADD;
        alu_a   = tmp2_q;
        alu_b   = tmp0_q;
        tmp2_d  = alu_res;
        state_d = S_CB_ADD2;
      end
      S_CB_ADD2: begin
        alu_op         = yuvrgb_pkg::ALU_ADD;
        alu_a          = tmp2_q;
        alu_b          = tmp1_q;
        addr_d[SEL_CB] = alu_res;
        sel_d          = SEL_Y;
        cur_d          = addr_q[SEL_Y];
        mod_d          = MOD_INIT;
        state_d        = S_RED;
      end
      // wrap the address into the store, one step per cycle
      S_RED: begin
        alu_op = yuvrgb_pkg::ALU_MOD;
        alu_a  = cur_q;
        alu_b  = mod_q;
        cur_d  = alu_res;
        if (POW2 || (mod_q == MOD_LAST)) begin
          state_d = wr_q ? S_WR : S_RD;
        end else begin
          mod_d = mod_q >> 1;
        end
      end
      S_RD: begin
        state_d = S_CAP;
      end
      S_CAP: begin
        case (sel_q)
          SEL_Y:   bytes_d.y  = ram_rdata;
          SEL_CR:  bytes_d.cr = ram_rdata;
          default: bytes_d.cb = ram_rdata;
        endcase
        if (sel_q == SEL_CB) begin
          state_d = S_ROM;
        end else begin
          sel_d   = 2'(sel_q + 2'd1);
          cur_d   = addr_q[2'(sel_q + 2'd1)];
          mod_d   = MOD_INIT;
          state_d = S_RED;
        end
      end
      S_WR: begin
        state_d = S_IDLE;
      end
      S_ROM: begin
        conv_load = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (outside_q) begin
            out_data_d = '{red: 8'd0, green: 8'd0, blue: 8'd0, outside_frame: 1'b1};
          end else begin
            out_data_d = '{red: conv_red, green: conv_green, blue: conv_blue,
                           outside_frame: 1'b0};
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      width_q     <= yuvrgb_pkg::WIDTH_W'(16);
      height_q    <= yuvrgb_pkg::HEIGHT_W'(16);
      format_q    <= yuvrgb_pkg::FMT_YV12;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          yuvrgb_pkg::CFG_WIDTH:  width_q  <= cfg_data_i;
          yuvrgb_pkg::CFG_HEIGHT: height_q <= cfg_data_i[yuvrgb_pkg::HEIGHT_W-1:0];
          yuvrgb_pkg::CFG_FORMAT: format_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    wr_q       <= wr_d;
    outside_q  <= outside_d;
    row_q      <= row_d;
    col_q      <= col_d;
    value_q    <= value_d;
    cur_q      <= cur_d;
    mod_q      <= mod_d;
    tmp0_q     <= tmp0_d;
    tmp1_q     <= tmp1_d;
    tmp2_q     <= tmp2_d;
    addr_q     <= addr_d;
    bytes_q    <= bytes_d;
    out_data_q <= out_data_d;
  end

endmodule

`default_nettype wire

### design/yuvrgb_checker.sv
// ----------------------------------------------------------------------------
// yuvrgb_checker
// port-level checks of the yuv to rgb frame store, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "yuv_frame_to_rgb_macros.svh"

module yuvrgb_checker (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_i,
  input wire logic                    out_valid_i,
  input wire logic                    out_stall_i,
  input wire yuvrgb_pkg::yuvrgb_out_t out_data_i
);

  // a stalled result holds
  `YFR_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_data_i))

  // an accepted transaction keeps the block busy in the next cycle
  `YFR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_i, in_stall_i)

  // a new result only appears at the end of a busy stretch
  `YFR_ASSERT_NOW(a_result_from_work, $rose(out_valid_i), $past(in_stall_i))

  // outside-frame results carry black
  `YFR_ASSERT_NOW(a_outside_black, out_valid_i && out_data_i.outside_frame,
    out_data_i.red == 8'd0 && out_data_i.green == 8'd0 && out_data_i.blue == 8'd0)

endmodule

bind yuv_frame_to_rgb yuvrgb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for yuv_frame_to_rgb
// fills the frame store byte by byte, requests pixels in both layouts and
// over a range of frame sizes, and checks every returned color against an
// in-bench prediction of the bt.601 conversion
// ----------------------------------------------------------------------------

module testbench;

  import yuvrgb_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 512;
  localparam int STORE_SIZE    = 1 << 20;
  localparam int IDLE_PCT      = 7;
  localparam int SETTLE_CYCLES = 40;    // margin for the last byte write to finish
  localparam int QUIET_LIMIT   = 2000;  // well above the slowest request

  // frame geometry and layout for each random phase; zero and oversized
  // sizes sit beside ordinary and odd ones
  localparam int PHASES = 10;
  localparam int PH_WIDTH  [PHASES] = '{1024, 2047, 0, 9, 1, 7, 7, 33, 2, 1024};
  localparam int PH_HEIGHT [PHASES] = '{512, 1023, 5, 0, 1, 5, 5, 17, 3, 1};
  localparam int PH_FORMAT [PHASES] = '{0, 1, 0, 1, 0, 0, 1, 1, 0, 1};
  localparam int PH_ITEMS  [PHASES] = '{200, 200, 30, 30, 80, 260, 260, 240, 150, 150};
  localparam int STEADY_PHASE = 5;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  yuvrgb_in_t  in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  yuvrgb_out_t out_data_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // geometry as the block holds it, updated when a register write lands
  int   cfg_width  = 16;
  int   cfg_height = 16;
  logic cfg_format = FMT_YV12;

  yuvrgb_in_t  pending_items [$];    // transactions waiting for the driver
  yuvrgb_out_t rgb_expected [$];     // predicted colors, oldest first
  logic [7:0]  frame_mirror [int];   // store content as accepted by the block
  bit          byte_written [int];   // addresses the stimulus has filled
  int          fail_count  = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;        // no idling on either side

  yuv_frame_to_rgb i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // oversized settings act as the largest frame
  function automatic int eff_width();
    return (cfg_width > MAX_W) ? MAX_W : cfg_width;
  endfunction

  function automatic int eff_height();
    return (cfg_height > MAX_H) ? MAX_H : cfg_height;
  endfunction

  // store addresses of the luma byte and the shared chroma bytes of a pixel
  function automatic void locate(input int col, input int row,
                                 output int luma_a, output int cr_a, output int cb_a);
    int w;
    int h;
    int pix;
    int part;
    w   = eff_width();
    h   = eff_height();
    pix = row * w + col;
    if (cfg_format == FMT_YV12) begin
      // quarter planes follow the luma plane, halves truncated
      part   = (row / 2) * (w / 2) + col / 2;
      luma_a = pix;
      cr_a   = w * h + part;
      cb_a   = w * h + (w / 2) * (h / 2) + part;
    end else begin
      // four bytes per pixel pair: y0 cb y1 cr
      part   = pix / 2 * 4;
      luma_a = pix * 2;
      cr_a   = part + 3;
      cb_a   = part + 1;
    end
    luma_a = luma_a % STORE_SIZE;
    cr_a   = cr_a % STORE_SIZE;
    cb_a   = cb_a % STORE_SIZE;
  endfunction

  // table terms, integer quotients truncated toward zero
  function automatic int luma_term(int v);
    return (v - 16) * 65280 / 219;
  endfunction

  function automatic int red_cr_term(int v);
    return (v - 128) * 356108 / 875;
  endfunction

  function automatic int green_cr_term(int v);
    return (v - 128) * (-25908) / 125;
  endfunction

  function automatic int green_cb_term(int v);
    return (v - 128) * (-87376) / 875;
  endfunction

  function automatic int blue_cb_term(int v);
    return (v - 128) * 450088 / 875;
  endfunction

  // clamp to 0..255<<8, then add 127 and keep the upper eight bits
  function automatic logic [7:0] to_channel(int sum);
    int s;
    s = sum;
    if (s < 0) s = 0;
    if (s > CHAN_MAX) s = CHAN_MAX;
    return 8'((s + 127) >> 8);
  endfunction

  function automatic yuvrgb_out_t convert_pixel(yuvrgb_in_t item);
    yuvrgb_out_t res;
    int          luma_a;
    int          cr_a;
    int          cb_a;
    int          yv;
    int          crv;
    int          cbv;
    int          ys;
    res = '0;
    if (int'(item.column) >= eff_width() || int'(item.row) >= eff_height()) begin
      res.outside_frame = 1'b1;
      return res;
    end
    locate(int'(item.column), int'(item.row), luma_a, cr_a, cb_a);
    yv  = int'(frame_mirror[luma_a]);
    crv = int'(frame_mirror[cr_a]);
    cbv = int'(frame_mirror[cb_a]);
    ys  = luma_term(yv);
    res.red   = to_channel(ys + red_cr_term(crv));
    res.green = to_channel(ys + green_cr_term(crv) + green_cb_term(cbv));
    res.blue  = to_channel(ys + blue_cb_term(cbv));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // fields a transaction does not use still get random content
  function automatic void queue_write(int addr, int value);
    yuvrgb_in_t item;
    item.mode         = MODE_WRITE;
    item.byte_address = addr[19:0];
    item.byte_value   = value[7:0];
    item.column       = 10'($urandom_range(1023));
    item.row          = 9'($urandom_range(511));
    pending_items.push_back(item);
    byte_written[addr % STORE_SIZE] = 1'b1;
  endfunction

  function automatic void queue_request(int col, int row);
    yuvrgb_in_t item;
    item.mode         = MODE_CONVERT;
    item.byte_address = 20'($urandom_range(20'hFFFFF));
    item.byte_value   = 8'($urandom_range(255));
    item.column       = col[9:0];
    item.row          = row[8:0];
    pending_items.push_back(item);
  endfunction

  // byte values lean toward the table corners
  function automatic int pick_byte();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 255;
      2:       return 16;
      3:       return 128;
      default: return $urandom_range(255);
    endcase
  endfunction

  // write all three bytes of an in-frame pixel, then ask for it
  function automatic void queue_pixel(int col, int row, int yv, int crv, int cbv);
    int luma_a;
    int cr_a;
    int cb_a;
    locate(col, row, luma_a, cr_a, cb_a);
    queue_write(luma_a, yv);
    queue_write(cr_a, crv);
    queue_write(cb_a, cbv);
    queue_request(col, row);
  endfunction

  // ask for an in-frame pixel again, filling only bytes never written
  function automatic void queue_revisit(int col, int row);
    int luma_a;
    int cr_a;
    int cb_a;
    locate(col, row, luma_a, cr_a, cb_a);
    if (!byte_written.exists(luma_a)) queue_write(luma_a, pick_byte());
    if (!byte_written.exists(cr_a)) queue_write(cr_a, pick_byte());
    if (!byte_written.exists(cb_a)) queue_write(cb_a, pick_byte());
    queue_request(col, row);
  endfunction

  // a request past the right or bottom edge, often right at it; a revisit for a full-size frame
  function automatic void queue_outside();
    int w;
    int h;
    w = eff_width();
    h = eff_height();
    if (w < MAX_W && (h >= MAX_H || $urandom_range(1) == 1)) begin
      queue_request((($urandom_range(3) == 0) ? w : $urandom_range(MAX_W - 1, w)),
                    $urandom_range(MAX_H - 1));
    end else if (h < MAX_H) begin
      queue_request($urandom_range(MAX_W - 1),
                    (($urandom_range(3) == 0) ? h : $urandom_range(MAX_H - 1, h)));
    end else begin
      queue_revisit($urandom_range(w - 1), $urandom_range(h - 1));
    end
  endfunction

  // mostly write-then-convert sequences, some revisits, edge requests and
  // stray writes anywhere in the store
  function automatic void random_part(int count);
    int target;
    int r;
    bit inside_ok;
    target    = pending_items.size() + count;
    inside_ok = (eff_width() > 0) && (eff_height() > 0);
    while (pending_items.size() < target) begin
      r = $urandom_range(99);
      if (inside_ok && r < 55) begin
        queue_pixel($urandom_range(eff_width() - 1), $urandom_range(eff_height() - 1),
                    pick_byte(), pick_byte(), pick_byte());
      end else if (inside_ok && r < 75) begin
        queue_revisit($urandom_range(eff_width() - 1), $urandom_range(eff_height() - 1));
      end else if (r < 88) begin
        queue_outside();
      end else begin
        queue_write($urandom_range(STORE_SIZE - 1), $urandom_range(255));
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sequencing helpers
  // ---------------------------------------------------------------------------

  // wait until the driver is empty and every prediction has been matched
  task automatic drain(int settle);
    while (pending_items.size() != 0 || in_valid_i || rgb_expected.size() != 0)
      @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // one register write; valid drops for a cycle before the next one
  task automatic cfg_write(logic [CFG_INDEX_W-1:0] index, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      CFG_WIDTH:  cfg_width  = value & 'h7FF;
      CFG_HEIGHT: cfg_height = value & 'h3FF;
      CFG_FORMAT: cfg_format = value[0];
      default:    ;
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset geometry, 16 x 16 planar:
    // all-zero and all-255 corners, neutral black, chroma extremes, edges
    queue_pixel(0, 0, 0, 0, 0);
    queue_pixel(15, 15, 255, 255, 255);
    queue_pixel(1, 0, 16, 128, 128);
    queue_pixel(3, 6, 235, 240, 16);
    queue_pixel(8, 9, 128, 16, 240);
    queue_request(16, 0);
    queue_request(0, 16);
    queue_request(MAX_W - 1, MAX_H - 1);
    queue_write(STORE_SIZE - 1, 255);
    drain(SETTLE_CYCLES);

    for (int p = 0; p < PHASES; p++) begin
      steady = (p == STEADY_PHASE);
      cfg_write(CFG_WIDTH, PH_WIDTH[p]);
      cfg_write(CFG_HEIGHT, PH_HEIGHT[p]);
      cfg_write(CFG_FORMAT, PH_FORMAT[p]);
      // opposite corners of the frame first, when it has any pixels
      if (eff_width() > 0 && eff_height() > 0) begin
        queue_pixel(eff_width() - 1, eff_height() - 1, pick_byte(), pick_byte(), pick_byte());
        queue_pixel(0, 0, pick_byte(), pick_byte(), pick_byte());
      end
      random_part(PH_ITEMS[p] / 2);
      // sender holds off until every color of the first half is back
      drain(0);
      random_part(PH_ITEMS[p] - PH_ITEMS[p] / 2);
      drain(SETTLE_CYCLES);
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: presents queued transactions, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.mode == MODE_CONVERT) begin
          rgb_expected.push_back(convert_pixel(in_data_i));
        end else begin
          frame_mirror[int'(in_data_i.byte_address) % STORE_SIZE] = in_data_i.byte_value;
        end
      end
      // a stalled payload stays put
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_items.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random stall, compares each color with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (rgb_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
          fail_count++;
        end else begin
          yuvrgb_out_t want;
          want = rgb_expected.pop_front();
          if (out_data_o.red !== want.red)
            report_field("red", want.red, out_data_o.red);
          if (out_data_o.green !== want.green)
            report_field("green", want.green, out_data_o.green);
          if (out_data_o.blue !== want.blue)
            report_field("blue", want.blue, out_data_o.blue);
          if (out_data_o.outside_frame !== want.outside_frame)
            report_field("outside_frame", want.outside_frame, out_data_o.outside_frame);
        end
      end
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any accepted transaction on any channel restarts the count
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
